// ===== hw/rtl/sid_pkg.sv =====
// sid_pkg: widths, constants and shared types of the segment intersection unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sid_pkg;
   localparam int COORD_W        = 16;
   localparam int VEC_W          = COORD_W + 1;
   localparam int PROD_W         = 2 * VEC_W;
   localparam int SUM_W          = PROD_W + 1;
   localparam int REM_W          = SUM_W + 1;
   localparam int THR_W          = 16;
   localparam int PARAM_W        = 13;
   localparam int FRAC_BITS_DEF  = 12;
   localparam int QUEUE_DEPTH    = 4;
   localparam logic [THR_W-1:0] THR_RESET = 16'd17;

   // item after classification, handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0]          abs_det;
      logic [SUM_W-1:0]          abs_tn;
      logic [SUM_W-1:0]          abs_sn;
      logic                      neg_t;
      logic                      neg_s;
      logic                      parallel;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [VEC_W-1:0]   ux;
      logic signed [VEC_W-1:0]   uy;
   } sid_work_type;

   // side data riding along the divider stages
   typedef struct packed {
      logic [SUM_W-1:0]          abs_det;
      logic                      neg_t;
      logic                      neg_s;
      logic                      ovf_t;
      logic                      ovf_s;
      logic                      parallel;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [VEC_W-1:0]   ux;
      logic signed [VEC_W-1:0]   uy;
   } sid_meta_type;
endpackage

// ===== hw/rtl/sid_front.sv =====
// sid_front: difference vectors, cross products, determinant and parallel test.
// Depends on sid_pkg.
`timescale 1ns / 1ps
module sid_front
   import sid_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] ax,
   input  logic signed [COORD_W-1:0] ay,
   input  logic signed [COORD_W-1:0] bx,
   input  logic signed [COORD_W-1:0] by_coord,
   input  logic signed [COORD_W-1:0] cx,
   input  logic signed [COORD_W-1:0] cy,
   input  logic signed [COORD_W-1:0] dx,
   input  logic signed [COORD_W-1:0] dy,
   input  logic [THR_W-1:0]          det_threshold,
   output logic                      out_valid,
   output sid_work_type              out_work
);
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [COORD_W-1:0] ax1_ff, ay1_ff, ax2_ff, ay2_ff, ax3_ff, ay3_ff;
   logic signed [VEC_W-1:0] ux1_ff, uy1_ff, vx1_ff, vy1_ff, wx1_ff, wy1_ff;
   logic signed [VEC_W-1:0] ux2_ff, uy2_ff, ux3_ff, uy3_ff;
   logic signed [PROD_W-1:0] p_uyvx_ff, p_uxvy_ff, p_vxwy_ff, p_vywx_ff;
   logic signed [PROD_W-1:0] p_uxwy_ff, p_uywx_ff;
   logic signed [SUM_W-1:0] det_ff, tn_ff, sn_ff;
   sid_work_type work_ff, work_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      // stage 1: vectors
      ux1_ff <= VEC_W'(bx) - VEC_W'(ax);
      uy1_ff <= VEC_W'(by_coord) - VEC_W'(ay);
      vx1_ff <= VEC_W'(dx) - VEC_W'(cx);
      vy1_ff <= VEC_W'(dy) - VEC_W'(cy);
      wx1_ff <= VEC_W'(cx) - VEC_W'(ax);
      wy1_ff <= VEC_W'(cy) - VEC_W'(ay);
      ax1_ff <= ax;
      ay1_ff <= ay;
      // stage 2: products
      p_uyvx_ff <= uy1_ff * vx1_ff;
      p_uxvy_ff <= ux1_ff * vy1_ff;
      p_vxwy_ff <= vx1_ff * wy1_ff;
      p_vywx_ff <= vy1_ff * wx1_ff;
      p_uxwy_ff <= ux1_ff * wy1_ff;
      p_uywx_ff <= uy1_ff * wx1_ff;
      ux2_ff <= ux1_ff;
      uy2_ff <= uy1_ff;
      ax2_ff <= ax1_ff;
      ay2_ff <= ay1_ff;
      // stage 3: cross sums
      det_ff <= SUM_W'(p_uyvx_ff) - SUM_W'(p_uxvy_ff);
      tn_ff  <= SUM_W'(p_vxwy_ff) - SUM_W'(p_vywx_ff);
      sn_ff  <= SUM_W'(p_uxwy_ff) - SUM_W'(p_uywx_ff);
      ux3_ff <= ux2_ff;
      uy3_ff <= uy2_ff;
      ax3_ff <= ax2_ff;
      ay3_ff <= ay2_ff;
      // stage 4: magnitudes and classification
      work_ff <= work_in;
   end

   always_comb begin
      work_in.abs_det  = det_ff[SUM_W-1] ? SUM_W'(-det_ff) : SUM_W'(det_ff);
      work_in.abs_tn   = tn_ff[SUM_W-1] ? SUM_W'(-tn_ff) : SUM_W'(tn_ff);
      work_in.abs_sn   = sn_ff[SUM_W-1] ? SUM_W'(-sn_ff) : SUM_W'(sn_ff);
      work_in.neg_t    = tn_ff[SUM_W-1] ^ det_ff[SUM_W-1];
      work_in.neg_s    = sn_ff[SUM_W-1] ^ det_ff[SUM_W-1];
      work_in.parallel = (work_in.abs_det == '0) ||
                         (work_in.abs_det < SUM_W'(det_threshold));
      work_in.ax       = ax3_ff;
      work_in.ay       = ay3_ff;
      work_in.ux       = ux3_ff;
      work_in.uy       = uy3_ff;
   end

   assign out_valid = v4_ff;
   assign out_work  = work_ff;
endmodule

// ===== hw/rtl/sid_queue.sv =====
// sid_queue: small register queue between front and back.
// Depends on sid_pkg.
`timescale 1ns / 1ps
module sid_queue
   import sid_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  sid_work_type push_data,
   input  logic         pop,
   output logic         pop_valid,
   output sid_work_type pop_data,
   output logic         full
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sid_work_type mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = push && (count_ff != CNT_W'(DEPTH));

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_W'(DEPTH));
endmodule

// ===== hw/rtl/sid_back.sv =====
// sid_back: pipelined restoring division for t and s, range test, point math.
// Depends on sid_pkg.
`timescale 1ns / 1ps
module sid_back
   import sid_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  sid_work_type              in_work,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic signed [COORD_W-1:0] rsp_px,
   output logic signed [COORD_W-1:0] rsp_py,
   output logic [PARAM_W-1:0]        rsp_t_param,
   output logic [PARAM_W-1:0]        rsp_s_param
);
   localparam int QW = FRAC_BITS + 1;          // quotient bits, value up to 2^F
   localparam int PW = QW + 1 + VEC_W;         // t*u product width

   logic              valid_ff [0:QW];
   sid_meta_type      meta_ff  [0:QW];
   logic [REM_W-1:0]  rt_ff    [0:QW];
   logic [REM_W-1:0]  rs_ff    [0:QW];
   logic [QW-1:0]     qt_ff    [0:QW];
   logic [QW-1:0]     qs_ff    [0:QW];

   // stage 0: load remainders, flag quotients of two or more
   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else       valid_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      meta_ff[0].abs_det  <= in_work.abs_det;
      meta_ff[0].neg_t    <= in_work.neg_t;
      meta_ff[0].neg_s    <= in_work.neg_s;
      meta_ff[0].ovf_t    <= REM_W'(in_work.abs_tn) >= {in_work.abs_det, 1'b0};
      meta_ff[0].ovf_s    <= REM_W'(in_work.abs_sn) >= {in_work.abs_det, 1'b0};
      meta_ff[0].parallel <= in_work.parallel;
      meta_ff[0].ax       <= in_work.ax;
      meta_ff[0].ay       <= in_work.ay;
      meta_ff[0].ux       <= in_work.ux;
      meta_ff[0].uy       <= in_work.uy;
      rt_ff[0] <= REM_W'(in_work.abs_tn);
      rs_ff[0] <= REM_W'(in_work.abs_sn);
      qt_ff[0] <= '0;
      qs_ff[0] <= '0;
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [REM_W-1:0] dv;
      logic             bt, bs;
      logic [REM_W-1:0] rt_n, rs_n;

      assign dv   = REM_W'(meta_ff[k-1].abs_det);
      assign bt   = rt_ff[k-1] >= dv;
      assign bs   = rs_ff[k-1] >= dv;
      assign rt_n = bt ? rt_ff[k-1] - dv : rt_ff[k-1];
      assign rs_n = bs ? rs_ff[k-1] - dv : rs_ff[k-1];

      always_ff @(posedge clock) begin
         if (reset) valid_ff[k] <= 1'b0;
         else       valid_ff[k] <= valid_ff[k-1];
      end

      always_ff @(posedge clock) begin
         meta_ff[k] <= meta_ff[k-1];
         rt_ff[k]   <= {rt_n[REM_W-2:0], 1'b0};
         rs_ff[k]   <= {rs_n[REM_W-2:0], 1'b0};
         qt_ff[k]   <= QW'({qt_ff[k-1], bt});
         qs_ff[k]   <= QW'({qs_ff[k-1], bs});
      end
   end

   // range test on the finished quotients
   sid_meta_type mf;
   logic [QW-1:0] qt, qs;
   logic t_ok, s_ok, hit_in;

   assign mf = meta_ff[QW];
   assign qt = qt_ff[QW];
   assign qs = qs_ff[QW];
   assign t_ok = !mf.ovf_t && !(qt[QW-1] && (qt[QW-2:0] != '0)) &&
                 !(mf.neg_t && (qt != '0));
   assign s_ok = !mf.ovf_s && !(qs[QW-1] && (qs[QW-2:0] != '0)) &&
                 !(mf.neg_s && (qs != '0));
   assign hit_in = !mf.parallel && t_ok && s_ok;

   // multiply stage
   logic                      mv_ff, mhit_ff;
   logic signed [PW-1:0]      prx_ff, pry_ff;
   logic [QW-1:0]             mqt_ff, mqs_ff;
   logic signed [COORD_W-1:0] max_ff, may_ff;

   always_ff @(posedge clock) begin
      if (reset) mv_ff <= 1'b0;
      else       mv_ff <= valid_ff[QW];
   end

   always_ff @(posedge clock) begin
      mhit_ff <= hit_in;
      prx_ff  <= $signed({1'b0, qt}) * mf.ux;
      pry_ff  <= $signed({1'b0, qt}) * mf.uy;
      mqt_ff  <= qt;
      mqs_ff  <= qs;
      max_ff  <= mf.ax;
      may_ff  <= mf.ay;
   end

   // scale back toward zero and add the start point
   logic signed [PW-1:0] sx, sy, px_full, py_full;
   logic [QW+PARAM_W-1:0] tq_ext, sq_ext;

   assign sx = prx_ff + $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{prx_ff[PW-1]}}});
   assign sy = pry_ff + $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{pry_ff[PW-1]}}});
   assign px_full = PW'(max_ff) + (sx >>> FRAC_BITS);
   assign py_full = PW'(may_ff) + (sy >>> FRAC_BITS);
   assign tq_ext  = {{PARAM_W{1'b0}}, mqt_ff};
   assign sq_ext  = {{PARAM_W{1'b0}}, mqs_ff};

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= mv_ff;
   end

   always_ff @(posedge clock) begin
      rsp_hit     <= mhit_ff;
      rsp_px      <= mhit_ff ? px_full[COORD_W-1:0] : '0;
      rsp_py      <= mhit_ff ? py_full[COORD_W-1:0] : '0;
      rsp_t_param <= mhit_ff ? tq_ext[PARAM_W-1:0] : '0;
      rsp_s_param <= mhit_ff ? sq_ext[PARAM_W-1:0] : '0;
   end
endmodule

// ===== hw/rtl/segment_intersection_2d_unit.sv =====
// segment_intersection_2d_unit: top level of the 2D segment intersection test.
// Depends on sid_pkg, sid_front, sid_queue, sid_back.
`timescale 1ns / 1ps
// Usage
//   Input: drive req_ax .. req_dy (signed fixed point, COORD_FRAC_BITS fraction
//   bits) and raise start. An item is taken at each clock edge where start is
//   high and busy is low; a new item may follow every cycle.
//   Output: each item yields exactly one result, shown for one cycle with
//   rsp_valid high. The receiver cannot stall; results leave in item order.
//   Path: the front spends 4 stages on vectors, products, sums and the parallel
//   test; the item then passes the queue's storage register, and the back spends
//   a load stage, one stage per quotient bit (COORD_FRAC_BITS + 1 of them), a
//   multiply stage and an output stage.
//   Throughput: one item per cycle; the divider is fully pipelined.
//   busy rises only if the front/back queue fills, which the back's steady
//   drain keeps from happening.
//   Config: csr_wr_en writes csr_wr_data into the parallel threshold; write
//   only while no item is in flight.
//   Reset: synchronous, clears all valid flags and the queue, and loads the
//   threshold with 17.
module segment_intersection_2d_unit
   import sid_pkg::*;
#(
   parameter int COORD_FRAC_BITS = FRAC_BITS_DEF
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_ax,
   input  logic signed [COORD_W-1:0] req_ay,
   input  logic signed [COORD_W-1:0] req_bx,
   input  logic signed [COORD_W-1:0] req_by_coord,
   input  logic signed [COORD_W-1:0] req_cx,
   input  logic signed [COORD_W-1:0] req_cy,
   input  logic signed [COORD_W-1:0] req_dx,
   input  logic signed [COORD_W-1:0] req_dy,
   input  logic                      csr_wr_en,
   input  logic [THR_W-1:0]          csr_wr_data,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic signed [COORD_W-1:0] rsp_px,
   output logic signed [COORD_W-1:0] rsp_py,
   output logic [PARAM_W-1:0]        rsp_t_param,
   output logic [PARAM_W-1:0]        rsp_s_param
);
   logic [THR_W-1:0] det_thr_ff;
   logic             accept;
   logic             f_valid, q_valid;
   sid_work_type     f_work, q_work;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset)          det_thr_ff <= THR_RESET;
      else if (csr_wr_en) det_thr_ff <= csr_wr_data;
   end

   assign accept = start && !busy;

   // front: classify
   sid_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .ax            (req_ax),
      .ay            (req_ay),
      .bx            (req_bx),
      .by_coord      (req_by_coord),
      .cx            (req_cx),
      .cy            (req_cy),
      .dx            (req_dx),
      .dy            (req_dy),
      .det_threshold (det_thr_ff),
      .out_valid     (f_valid),
      .out_work      (f_work)
   );

   // queue between the halves; back pops whenever an item waits
   sid_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_work),
      .pop       (1'b1),
      .pop_valid (q_valid),
      .pop_data  (q_work),
      .full      (busy)
   );

   // back: divide, range test, point
   sid_back #(.FRAC_BITS(COORD_FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_work     (q_work),
      .rsp_valid   (rsp_valid),
      .rsp_hit     (rsp_hit),
      .rsp_px      (rsp_px),
      .rsp_py      (rsp_py),
      .rsp_t_param (rsp_t_param),
      .rsp_s_param (rsp_s_param)
   );

`ifndef SYNTH
   // a miss carries all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_px == '0 && rsp_py == '0 &&
                                   rsp_t_param == '0 && rsp_s_param == '0))
      else $error("miss result with nonzero payload");
   // the back drains every cycle, so the queue never fills
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("front/back queue filled");
   // no stale strobe right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");
   // t on a hit never exceeds one
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_t_param <= PARAM_W'(1 << COORD_FRAC_BITS) ||
                                  COORD_FRAC_BITS >= PARAM_W))
      else $error("t out of range on hit");
`endif
endmodule

// ===== tb/sv/segment_intersection_2d_unit_test.sv =====
// segment_intersection_2d_unit_test: self-checking bench for the 2D segment intersection unit.
// Depends on sid_pkg and segment_intersection_2d_unit; needs nothing else.
`timescale 1ns / 1ps
module segment_intersection_2d_unit_test;
   import sid_pkg::*;

   localparam int FRAC      = FRAC_BITS_DEF;
   localparam int LATENCY   = FRAC + 9;
   localparam int N_RANDOM  = 2000;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [COORD_W-1:0] coord_type;

   // one segment pair
   typedef struct {
      coord_type ax, ay, bx, by, cx, cy, dx, dy;
   } seg_pair_type;

   typedef struct packed {
      logic               hit;
      coord_type          px;
      coord_type          py;
      logic [PARAM_W-1:0] t;
      logic [PARAM_W-1:0] s;
   } crossing_type;

   // directed row: pair plus an optional typed-in answer
   typedef struct {
      seg_pair_type pair;
      bit           known;
      crossing_type answer;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_ax = '0, req_ay = '0, req_bx = '0, req_by_coord = '0;
   coord_type req_cx = '0, req_cy = '0, req_dx = '0, req_dy = '0;
   logic csr_wr_en = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;
   logic rsp_valid, rsp_hit;
   coord_type rsp_px, rsp_py;
   logic [PARAM_W-1:0] rsp_t_param, rsp_s_param;

   segment_intersection_2d_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ax(req_ax), .req_ay(req_ay), .req_bx(req_bx), .req_by_coord(req_by_coord),
      .req_cx(req_cx), .req_cy(req_cy), .req_dx(req_dx), .req_dy(req_dy),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_px(rsp_px), .rsp_py(rsp_py),
      .rsp_t_param(rsp_t_param), .rsp_s_param(rsp_s_param)
   );

   always #5 clock = ~clock;

   // predictor copy of the one register
   logic [THR_W-1:0] det_limit = THR_RESET;
   crossing_type pending_crossings[$];
   int  n_errors   = 0;
   int  n_accepted = 0;
   int  n_results  = 0;
   int  n_hits     = 0;
   longint n_cycles = 0;
   int  idle_pct   = 0;

   // Truncating signed divide on 64-bit values; SV '/' already truncates toward zero.
   function automatic crossing_type predict_crossing(seg_pair_type p,
                                                     logic [THR_W-1:0] limit);
      crossing_type r;
      longint one, ux, uy, vx, vy, wx, wy, det, tn, sn, t, s, mag;
      one = longint'(1) << FRAC;
      ux = longint'(p.bx) - longint'(p.ax);
      uy = longint'(p.by) - longint'(p.ay);
      vx = longint'(p.dx) - longint'(p.cx);
      vy = longint'(p.dy) - longint'(p.cy);
      wx = longint'(p.cx) - longint'(p.ax);
      wy = longint'(p.cy) - longint'(p.ay);
      det = uy * vx - ux * vy;
      tn  = vx * wy - vy * wx;
      sn  = ux * wy - uy * wx;
      r = '{hit: 1'b0, px: '0, py: '0, t: '0, s: '0};
      mag = det < 0 ? -det : det;
      // exact zero is parallel even with a zero threshold
      if (det == 0 || mag < longint'(limit)) return r;
      t = (tn * one) / det;
      s = (sn * one) / det;
      if (t < 0 || t > one || s < 0 || s > one) return r;
      r.hit = 1'b1;
      r.px  = coord_type'(longint'(p.ax) + (t * ux) / one);
      r.py  = coord_type'(longint'(p.ay) + (t * uy) / one);
      r.t   = t[PARAM_W-1:0];
      r.s   = s[PARAM_W-1:0];
      return r;
   endfunction

   function automatic seg_pair_type make_pair(int ax, int ay, int bx, int by,
                                              int cx, int cy, int dx, int dy);
      seg_pair_type p;
      p.ax = coord_type'(ax); p.ay = coord_type'(ay);
      p.bx = coord_type'(bx); p.by = coord_type'(by);
      p.cx = coord_type'(cx); p.cy = coord_type'(cy);
      p.dx = coord_type'(dx); p.dy = coord_type'(dy);
      return p;
   endfunction

   function automatic coord_type rand_coord(int range);
      return coord_type'($urandom_range(2 * range) - range);
   endfunction

   // Mostly pairs that cross near a common point, so hits are plentiful;
   // the rest is full-range noise and near-parallel pairs.
   function automatic seg_pair_type random_pair();
      seg_pair_type p;
      int kind, mx, my, range;
      kind = $urandom_range(9);
      if (kind < 2) begin
         p.ax = coord_type'($urandom); p.ay = coord_type'($urandom);
         p.bx = coord_type'($urandom); p.by = coord_type'($urandom);
         p.cx = coord_type'($urandom); p.cy = coord_type'($urandom);
         p.dx = coord_type'($urandom); p.dy = coord_type'($urandom);
      end else if (kind < 3) begin
         // nearly parallel: CD is AB shifted with tiny jitter
         p.ax = rand_coord(20000); p.ay = rand_coord(20000);
         p.bx = rand_coord(20000); p.by = rand_coord(20000);
         p.cx = coord_type'(p.ax + rand_coord(300));
         p.cy = coord_type'(p.ay + rand_coord(300));
         p.dx = coord_type'(p.bx + rand_coord(3) + (p.cx - p.ax));
         p.dy = coord_type'(p.by + rand_coord(3) + (p.cy - p.ay));
      end else begin
         range = (kind < 6) ? 16000 : 400;
         mx = $urandom_range(16000) - 8000;
         my = $urandom_range(16000) - 8000;
         p.ax = coord_type'(mx + rand_coord(range)); p.ay = coord_type'(my + rand_coord(range));
         p.bx = coord_type'(2 * mx - p.ax);          p.by = coord_type'(2 * my - p.ay);
         p.cx = coord_type'(mx + rand_coord(range)); p.cy = coord_type'(my + rand_coord(range));
         p.dx = coord_type'(2 * mx - p.cx);          p.dy = coord_type'(2 * my - p.cy);
      end
      return p;
   endfunction

   // Present one pair and hold it until accepted; optional random gap first.
   // start stays high afterwards so the next pair can follow with no gap.
   task automatic send_pair(seg_pair_type p);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_ax <= p.ax; req_ay <= p.ay; req_bx <= p.bx; req_by_coord <= p.by;
      req_cx <= p.cx; req_cy <= p.cy; req_dx <= p.dx; req_dy <= p.dy;
      // busy is stable between edges; look at it mid-cycle
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_crossings.insert(pending_crossings.size(), predict_crossing(p, det_limit));
      n_accepted++;
   endtask

   // Wait for every expected result, then let the pipe drain before a register write.
   task automatic drain_pipe();
      start <= 1'b0;
      while (pending_crossings.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_limit(logic [THR_W-1:0] value);
      drain_pipe();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      det_limit = value;
   endtask

   // Result checker: compare each strobed result against the oldest expectation.
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_valid) begin
         n_results++;
         if (pending_crossings.size() == 0) begin
            $display("%0t: unexpected result hit=%0b px=%0d py=%0d t=%0d s=%0d", $time,
                     rsp_hit, rsp_px, rsp_py, rsp_t_param, rsp_s_param);
            n_errors++;
         end else begin
            want = pending_crossings.pop_front();
            if (want.hit) n_hits++;
            if (rsp_hit !== want.hit || rsp_px !== want.px || rsp_py !== want.py ||
                rsp_t_param !== want.t || rsp_s_param !== want.s) begin
               $display("%0t: mismatch expected hit=%0b px=%0d py=%0d t=%0d s=%0d", $time,
                        want.hit, $signed(want.px), $signed(want.py), want.t, want.s);
               $display("%0t:          actual   hit=%0b px=%0d py=%0d t=%0d s=%0d", $time,
                        rsp_hit, rsp_px, rsp_py, rsp_t_param, rsp_s_param);
               n_errors++;
            end
         end
      end
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still owed", $time, pending_crossings.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   directed_row_type directed_rows[$];

   task automatic add_row(seg_pair_type p, bit known, crossing_type a);
      directed_row_type r;
      r.pair = p; r.known = known; r.answer = a;
      directed_rows.insert(directed_rows.size(), r);
   endtask

   initial begin
      crossing_type miss;
      crossing_type want;
      int phase;
      logic [THR_W-1:0] limits[4];
      miss = '{hit: 1'b0, px: '0, py: '0, t: '0, s: '0};

      // Directed rows. Known answers typed in where obvious; the rest use the predictor.
      // Cross through the origin at the midpoints: t = s = 1/2.
      add_row(make_pair(-4096, 0, 4096, 0, 0, -4096, 0, 4096), 1,
              '{hit: 1'b1, px: '0, py: '0, t: 13'd2048, s: 13'd2048});
      // Crossing at A itself: t = 0.
      add_row(make_pair(0, 0, 4096, 0, 0, -4096, 0, 4096), 1,
              '{hit: 1'b1, px: '0, py: '0, t: '0, s: 13'd2048});
      // Crossing at B: t = 1.
      add_row(make_pair(-4096, 0, 0, 0, 0, -4096, 0, 4096), 1,
              '{hit: 1'b1, px: '0, py: '0, t: 13'd4096, s: 13'd2048});
      // Identical collinear segments: zero determinant, a miss.
      add_row(make_pair(0, 0, 4096, 4096, 0, 0, 4096, 4096), 1, miss);
      // Degenerate points.
      add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, miss);
      // Lines cross but beyond the segments.
      add_row(make_pair(-4096, 0, -2048, 0, 0, -4096, 0, 4096), 1, miss);
      // Full-scale extremes.
      add_row(make_pair(-32768, -32768, 32767, 32767,
                        -32768, 32767, 32767, -32768), 0, miss);
      add_row(make_pair(32767, -32768, -32768, 32767,
                        32767, 32767, -32768, -32768), 0, miss);
      add_row(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 0, miss);
      add_row(make_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1, miss);
      // Tiny determinant near the reset threshold: 4 and 25.
      add_row(make_pair(0, 0, 2, 0, 1, -1, 1, 1), 0, miss);
      add_row(make_pair(0, 0, 5, 0, 2, -2, 2, 3), 0, miss);
      // Truncation near the ends: quotients just outside [0,1].
      add_row(make_pair(0, 0, 12288, 1, 12289, -8192, 12289, 8192), 0, miss);
      add_row(make_pair(0, 0, 12288, 0, -1, -3, -1, 12288), 0, miss);
      add_row(make_pair(100, 200, 7000, -3000, 300, -2000, 5000, 4000), 0, miss);

      limits[0] = 16'd0; limits[1] = 16'hFFFF; limits[2] = 16'd1000; limits[3] = 16'd17;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset threshold, then at zero and maximum.
      for (int pass = 0; pass < 3; pass++) begin
         if (pass == 1) write_limit(16'd0);
         if (pass == 2) write_limit(16'hFFFF);
         foreach (directed_rows[i]) begin
            send_pair(directed_rows[i].pair);
            if (directed_rows[i].known && pass == 0) begin
               want = pending_crossings[$];
               if (want !== directed_rows[i].answer) begin
                  $display("%0t: row %0d predictor disagrees with typed answer", $time, i);
                  n_errors++;
               end
            end
         end
      end

      // Random part in phases of idling and threshold settings.
      for (phase = 0; phase < 8; phase++) begin
         write_limit((phase == 7) ? 16'($urandom) : limits[phase % 4]);
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 53;
            2: idle_pct = 30;
            default: idle_pct = 10;
         endcase
         for (int k = 0; k < N_RANDOM / 8; k++) begin
            send_pair(random_pair());
            // sender holds off until nothing is owed, once per phase
            if (k == 100) begin
               start <= 1'b0;
               while (pending_crossings.size() != 0) @(posedge clock);
            end
         end
      end

      drain_pipe();
      $display("Sent %0d segment pairs over 8 threshold/idle phases; %0d results, %0d hits.",
               n_accepted, n_results, n_hits);
      if (n_errors == 0 && pending_crossings.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
